/* rtl/core/asft_pkg.sv */
package asft_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_DELAY   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BIT_PERIOD    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OWN_ADDRESS   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MATCH_CODE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLY_ADDRESS = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLY_CODE    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLY_DATA    = 3'd6;

  // register reset values
  localparam logic [15:0] FIRST_DELAY_RST   = 16'hE4E2;
  localparam logic [15:0] BIT_PERIOD_RST    = 16'h9896;
  localparam logic [2:0]  OWN_ADDRESS_RST   = 3'd2;
  localparam logic [2:0]  MATCH_CODE_RST    = 3'd1;
  localparam logic [2:0]  REPLY_ADDRESS_RST = 3'd1;
  localparam logic [2:0]  REPLY_CODE_RST    = 3'd2;
  localparam logic [7:0]  REPLY_DATA_RST    = 8'd5;

  // frame layout: bit positions within a frame
  localparam logic [4:0] ADDR_FIRST = 5'd1;
  localparam logic [4:0] ADDR_LAST  = 5'd3;
  localparam logic [4:0] CODE_FIRST = 5'd4;
  localparam logic [4:0] CODE_LAST  = 5'd6;
  localparam logic [4:0] DATA_FIRST = 5'd7;
  localparam logic [4:0] DATA_LAST  = 5'd14;
  localparam logic [4:0] TAIL_POS   = 5'd15;
  localparam logic [4:0] LAST_INDEX = 5'd16;

  // live configuration
  typedef struct packed {
    logic [15:0] first_delay;
    logic [15:0] bit_period;
    logic [2:0]  own_address;
    logic [2:0]  match_code;
    logic [2:0]  reply_address;
    logic [2:0]  reply_code;
    logic [7:0]  reply_data;
  } cfg_t;

endpackage

/* rtl/core/addressed_serial_frame_transceiver.sv */
// Receives addressed serial frames and answers a matching one with a reply frame.
// Each input item is one prescaled timer tick carrying the sampled receive level;
// each item yields exactly one result item with the line and frame status after
// that tick. One item is taken per clock with both sides flowing; a result is
// presented once its item has passed the input register and the sequencer update
// into the result register, and it is held there until out_ready takes it.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata and take
// effect at the next bit event.
module addressed_serial_frame_transceiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            rx_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            tx_level,
  output logic                            tx_active,
  output logic                            rx_busy,
  output logic                            frame_done,
  output logic [2:0]                      frame_address,
  output logic [2:0]                      frame_code,
  output logic [7:0]                      frame_data,
  output logic                            reply_started,
  input  logic                            cfg_we,
  input  logic [asft_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [asft_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import asft_pkg::*;

  cfg_t cfg;
  logic s1_valid;
  logic s1_rx;
  logic take;

  // input register
  assign in_ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_rx <= rx_level;
    end
  end

  // configuration registers
  asft_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // frame sequencer and result register
  asft_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (s1_valid),
    .item_rx       (s1_rx),
    .out_ready     (out_ready),
    .take          (take),
    .out_valid     (out_valid),
    .tx_level      (tx_level),
    .tx_active     (tx_active),
    .rx_busy       (rx_busy),
    .frame_done    (frame_done),
    .frame_address (frame_address),
    .frame_code    (frame_code),
    .frame_data    (frame_data),
    .reply_started (reply_started)
  );

`ifndef SYNTH
  // never receiving and sending at once
  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tx_active && rx_busy))
    else $error("tx_active and rx_busy both high");

  // a reply only starts on a completed frame and puts the block into sending
  a_reply_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reply_started) |-> (frame_done && tx_active))
    else $error("reply_started without frame completion");

  // a completed frame leaves the receiver
  a_done_idle_rx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> !rx_busy)
    else $error("frame_done while still receiving");

  // an empty result register never blocks the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with result register empty");
`endif

endmodule

/* rtl/core/asft_cfg.sv */
module asft_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [asft_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [asft_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output asft_pkg::cfg_t                  cfg
);
  import asft_pkg::*;

  // register file, written one register at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_delay   <= FIRST_DELAY_RST;
      cfg.bit_period    <= BIT_PERIOD_RST;
      cfg.own_address   <= OWN_ADDRESS_RST;
      cfg.match_code    <= MATCH_CODE_RST;
      cfg.reply_address <= REPLY_ADDRESS_RST;
      cfg.reply_code    <= REPLY_CODE_RST;
      cfg.reply_data    <= REPLY_DATA_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIRST_DELAY:   cfg.first_delay   <= cfg_wdata;
        REG_BIT_PERIOD:    cfg.bit_period    <= cfg_wdata;
        REG_OWN_ADDRESS:   cfg.own_address   <= cfg_wdata[2:0];
        REG_MATCH_CODE:    cfg.match_code    <= cfg_wdata[2:0];
        REG_REPLY_ADDRESS: cfg.reply_address <= cfg_wdata[2:0];
        REG_REPLY_CODE:    cfg.reply_code    <= cfg_wdata[2:0];
        REG_REPLY_DATA:    cfg.reply_data    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/asft_core.sv */
module asft_core (
  input  logic           clk,
  input  logic           rst,
  input  asft_pkg::cfg_t cfg,
  input  logic           item_valid,
  input  logic           item_rx,
  input  logic           out_ready,
  output logic           take,
  output logic           out_valid,
  output logic           tx_level,
  output logic           tx_active,
  output logic           rx_busy,
  output logic           frame_done,
  output logic [2:0]     frame_address,
  output logic [2:0]     frame_code,
  output logic [7:0]     frame_data,
  output logic           reply_started
);
  import asft_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_t;

  mode_t       mode, mode_next;
  logic [4:0]  bit_index, bit_index_next;
  logic [15:0] tick_count, tick_count_next;
  logic [2:0]  got_address, got_address_next;
  logic [2:0]  got_code, got_code_next;
  logic [7:0]  got_data, got_data_next;
  logic        line_out, line_out_next;
  logic        prev_rx;
  logic        done, started, reply_bit;
  logic [1:0]  addr_pos, code_pos;
  logic [2:0]  data_pos;

  // item moves into the result register when it is free or being drained
  assign take = item_valid && (!out_valid || out_ready);

  // field bit positions, msb first
  assign addr_pos = 2'(ADDR_LAST - bit_index);
  assign code_pos = 2'(CODE_LAST - bit_index);
  assign data_pos = 3'(DATA_LAST - bit_index);

  // reply frame bit for the current index
  always_comb begin
    if (bit_index == 5'd0) begin
      reply_bit = 1'b1;
    end else if (bit_index <= ADDR_LAST) begin
      reply_bit = cfg.reply_address[addr_pos];
    end else if (bit_index <= CODE_LAST) begin
      reply_bit = cfg.reply_code[code_pos];
    end else if (bit_index <= DATA_LAST) begin
      reply_bit = cfg.reply_data[data_pos];
    end else begin
      reply_bit = 1'b0;
    end
  end

  // one tick of the frame sequencer
  always_comb begin
    mode_next        = mode;
    bit_index_next   = bit_index;
    tick_count_next  = tick_count;
    got_address_next = got_address;
    got_code_next    = got_code;
    got_data_next    = got_data;
    line_out_next    = line_out;
    done             = 1'b0;
    started          = 1'b0;
    unique case (mode)
      MODE_RX: begin
        if (tick_count == 16'd0) begin
          tick_count_next = cfg.bit_period;
          if (bit_index >= ADDR_FIRST && bit_index <= ADDR_LAST) begin
            got_address_next[addr_pos] = got_address[addr_pos] | item_rx;
            bit_index_next = bit_index + 5'd1;
          end else if (bit_index >= CODE_FIRST && bit_index <= CODE_LAST) begin
            got_code_next[code_pos] = got_code[code_pos] | item_rx;
            bit_index_next = bit_index + 5'd1;
          end else if (bit_index >= DATA_FIRST && bit_index <= DATA_LAST) begin
            got_data_next[data_pos] = got_data[data_pos] | item_rx;
            bit_index_next = bit_index + 5'd1;
          end else if (bit_index == TAIL_POS) begin
            bit_index_next = bit_index + 5'd1;
          end else begin
            done           = 1'b1;
            mode_next      = MODE_IDLE;
            bit_index_next = 5'd0;
            if (got_address == cfg.own_address && got_code == cfg.match_code) begin
              started   = 1'b1;
              mode_next = MODE_TX;
            end
          end
        end else begin
          tick_count_next = tick_count - 16'd1;
        end
      end
      MODE_TX: begin
        if (tick_count == 16'd0) begin
          tick_count_next = cfg.bit_period;
          if (bit_index < LAST_INDEX) begin
            line_out_next  = reply_bit;
            bit_index_next = bit_index + 5'd1;
          end else begin
            mode_next      = MODE_IDLE;
            bit_index_next = 5'd0;
          end
        end else begin
          tick_count_next = tick_count - 16'd1;
        end
      end
      default: begin
        // idle, and the unused code acts as idle
        if (!prev_rx && item_rx) begin
          mode_next        = MODE_RX;
          bit_index_next   = ADDR_FIRST;
          tick_count_next  = cfg.first_delay;
          got_address_next = 3'd0;
          got_code_next    = 3'd0;
          got_data_next    = 8'd0;
        end
      end
    endcase
  end

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      bit_index   <= 5'd0;
      tick_count  <= 16'd0;
      got_address <= 3'd0;
      got_code    <= 3'd0;
      got_data    <= 8'd0;
      line_out    <= 1'b0;
      prev_rx     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        mode          <= mode_next;
        bit_index     <= bit_index_next;
        tick_count    <= tick_count_next;
        got_address   <= got_address_next;
        got_code      <= got_code_next;
        got_data      <= got_data_next;
        line_out      <= line_out_next;
        prev_rx       <= item_rx;
        out_valid     <= 1'b1;
        tx_level      <= line_out_next;
        tx_active     <= (mode_next == MODE_TX);
        rx_busy       <= (mode_next == MODE_RX);
        frame_done    <= done;
        frame_address <= got_address_next;
        frame_code    <= got_code_next;
        frame_data    <= got_data_next;
        reply_started <= started;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
